// File: rtl/hashed_key_count_table_defines.svh
// Assertion macros shared by the hashed key count table RTL.
// Depends on clk_i and rst_ni being visible in the module that expands them.
`ifndef HASHED_KEY_COUNT_TABLE_DEFINES_SVH
`define HASHED_KEY_COUNT_TABLE_DEFINES_SVH

// same-cycle implication
`define HKCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HKCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hkct_pkg.sv
// Shared types of the hashed key count table: datapath commands and status.
// No dependencies.
package hkct_pkg;

  typedef enum logic [4:0] {
    CMD_CLEAR,
    CMD_TAKE,
    CMD_HASH,
    CMD_MOD,
    CMD_PINIT,
    CMD_PRD,
    CMD_PCHK,
    CMD_CRD,
    CMD_CCHK,
    CMD_NEXT,
    CMD_INSW,
    CMD_HIT,
    CMD_FAIL,
    CMD_DNEXT,
    CMD_DRD,
    CMD_DUCHK,
    CMD_LRD,
    CMD_LWR,
    CMD_DDEC,
    CMD_CPW,
    CMD_CPCLR,
    CMD_OUT
  } hkct_cmd_e;

  typedef struct packed {
    logic key_done;
    logic bc_last;
    logic mc_last;
    logic used;
    logic word_eq;
    logic wc_last;
    logic n_last;
    logic idx_last;
    logic dec_free;
    logic stays;
    logic out_free;
    logic kind;
  } hkct_status_t;

endpackage

// File: rtl/hkct_ctrl.sv
// Controller of the hashed key count table: sequences clearing, hashing,
// probing, insertion and backward-shift deletion. Depends on hkct_pkg.
module hkct_ctrl
  import hkct_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hkct_status_t status_i,
  output hkct_cmd_e    cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_TAKE, S_HASH, S_MOD, S_PINIT, S_PRD, S_PCHK, S_CRD, S_CCHK,
    S_NEXT, S_INSW, S_HIT, S_FAIL, S_DNEXT, S_DRD, S_DUCHK, S_LRD, S_LWR,
    S_DDEC, S_CPW, S_CPCLR, S_OUT
  } state_e;

  state_e state_q;
  logic   rehash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      rehash_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: if (status_i.idx_last) state_q <= S_TAKE;
        S_TAKE: begin
          if (status_i.key_done) begin
            state_q  <= S_HASH;
            rehash_q <= 1'b0;
          end
        end
        S_HASH:  if (status_i.bc_last) state_q <= S_MOD;
        S_MOD:   if (status_i.mc_last) state_q <= rehash_q ? S_DDEC : S_PINIT;
        S_PINIT: state_q <= S_PRD;
        S_PRD:   state_q <= S_PCHK;
        S_PCHK: begin
          if (status_i.used) state_q <= S_CRD;
          else state_q <= status_i.kind ? S_FAIL : S_INSW;
        end
        S_CRD:   state_q <= S_CCHK;
        S_CCHK: begin
          if (!status_i.word_eq) state_q <= S_NEXT;
          else if (status_i.wc_last) state_q <= S_HIT;
          else state_q <= S_CRD;
        end
        S_NEXT:  state_q <= status_i.n_last ? S_FAIL : S_PRD;
        S_INSW:  if (status_i.wc_last) state_q <= S_OUT;
        S_HIT:   state_q <= status_i.dec_free ? S_DNEXT : S_OUT;
        S_FAIL:  state_q <= S_OUT;
        S_DNEXT: state_q <= status_i.n_last ? S_OUT : S_DRD;
        S_DRD:   state_q <= S_DUCHK;
        S_DUCHK: state_q <= status_i.used ? S_LRD : S_OUT;
        S_LRD:   state_q <= S_LWR;
        S_LWR: begin
          if (status_i.wc_last) begin
            state_q  <= S_HASH;
            rehash_q <= 1'b1;
          end else begin
            state_q <= S_LRD;
          end
        end
        S_DDEC:  state_q <= status_i.stays ? S_DNEXT : S_CPW;
        S_CPW:   if (status_i.wc_last) state_q <= S_CPCLR;
        S_CPCLR: state_q <= S_DNEXT;
        S_OUT:   if (status_i.out_free) state_q <= S_TAKE;
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_CLEAR: cmd_o = CMD_CLEAR;
      S_TAKE:  cmd_o = CMD_TAKE;
      S_HASH:  cmd_o = CMD_HASH;
      S_MOD:   cmd_o = CMD_MOD;
      S_PINIT: cmd_o = CMD_PINIT;
      S_PRD:   cmd_o = CMD_PRD;
      S_PCHK:  cmd_o = CMD_PCHK;
      S_CRD:   cmd_o = CMD_CRD;
      S_CCHK:  cmd_o = CMD_CCHK;
      S_NEXT:  cmd_o = CMD_NEXT;
      S_INSW:  cmd_o = CMD_INSW;
      S_HIT:   cmd_o = CMD_HIT;
      S_FAIL:  cmd_o = CMD_FAIL;
      S_DNEXT: cmd_o = CMD_DNEXT;
      S_DRD:   cmd_o = CMD_DRD;
      S_DUCHK: cmd_o = CMD_DUCHK;
      S_LRD:   cmd_o = CMD_LRD;
      S_LWR:   cmd_o = CMD_LWR;
      S_DDEC:  cmd_o = CMD_DDEC;
      S_CPW:   cmd_o = CMD_CPW;
      S_CPCLR: cmd_o = CMD_CPCLR;
      S_OUT:   cmd_o = CMD_OUT;
      default: cmd_o = CMD_CLEAR;
    endcase
  end

endmodule

// File: rtl/hkct_dp.sv
// Datapath of the hashed key count table: key assembly, FNV-1 hash unit,
// reciprocal modulo unit, slot memories and the result register.
// Depends on hkct_pkg and hashed_key_count_table_defines.svh.
`include "hashed_key_count_table_defines.svh"

module hkct_dp
  import hkct_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int KEY_BYTES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hkct_cmd_e    cmd_i,
  output hkct_status_t status_o,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,  // key_word [63:0], amount [95:64]
  input  logic         s_axis_tlast_i,
  input  logic         s_axis_tuser_i,  // kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,  // count [31:0]
  output logic [1:0]   m_axis_tuser_o   // status [1:0]
);

  localparam int KW  = (KEY_BYTES + 7) / 8;
  localparam int PW  = (KW > 1) ? $clog2(KW) : 1;
  localparam int SW  = $clog2(SLOTS);
  localparam int BCW = PW + 3;
  localparam int AW  = SW + PW;

  localparam logic [63:0] HashBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] HashLow   = 64'h00000000000001b3;
  localparam logic [1:0]  StOk       = 2'd0;
  localparam logic [1:0]  StNotFound = 2'd1;
  localparam logic [1:0]  StFull     = 2'd2;

  // ceil(2^(32+SW) / SLOTS): exact quotient for any dividend below 2^32
  localparam logic [63:0] RecipFull = ((64'd1 << (32 + SW)) + 64'(SLOTS) - 64'd1)
                                      / 64'(SLOTS);
  localparam logic [32:0] Recip     = RecipFull[32:0];

  function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
    nxt = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  // storage
  logic [63:0] key_q     [KW];
  logic [63:0] scratch_q [KW];
  logic [63:0] key_mem   [SLOTS << PW];
  logic [32:0] cnt_mem   [SLOTS];
  logic [63:0] key_rdata_q;
  logic [32:0] cnt_rdata_q;

  logic [PW-1:0]  pos_q, wc_q;
  logic [SW-1:0]  idx_q, n_q, hole_q, j_q, r_q;
  logic [BCW-1:0] bc_q;
  logic [2:0]     mc_q;
  logic [63:0]    h_q, sh_q;
  logic [31:0]    mod_x_q;
  logic [64:0]    mod_prod_q;
  logic           hsel_q, kind_q;
  logic [31:0]    amount_q, cur_cnt_q, mv_cnt_q, res_cnt_q;
  logic [1:0]     res_st_q;
  logic           m_tvalid_q;
  logic [31:0]    m_tdata_q;
  logic [1:0]     m_tuser_q;

  logic           accept, complete, out_free, wc_last, bc_last;
  logic [PW-1:0]  ridx;
  logic [63:0]    src_word, hmul, hnext;
  logic [7:0]     hbyte;
  logic [31:0]    mod_x, mod_quo, mod_rem;
  logic [31:0]    hit_cnt;
  logic           dec_free, stays;
  logic           key_we, cnt_we;
  logic [AW-1:0]  key_waddr, key_raddr;
  logic [63:0]    key_wdata;
  logic [SW-1:0]  cnt_waddr, cnt_raddr;
  logic [32:0]    cnt_wdata;

  assign s_axis_tready_o = (cmd_i == CMD_TAKE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign complete = s_axis_tlast_i || (pos_q == PW'(KW - 1));
  assign out_free = !m_tvalid_q || m_axis_tready_i;
  assign wc_last  = (wc_q == PW'(KW - 1));
  assign bc_last  = (bc_q == BCW'(KEY_BYTES - 1));

  // hash unit: one byte a step, multiply by 2^40 + 0x1b3 then xor
  assign ridx     = (cmd_i == CMD_HASH) ? bc_q[BCW-1:3] : wc_q;
  assign src_word = hsel_q ? scratch_q[ridx] : key_q[ridx];
  assign hbyte    = 8'(src_word >> {bc_q[2:0], 3'b000});
  assign hmul     = (h_q << 40) + (h_q * HashLow);
  assign hnext    = hmul ^ {56'd0, hbyte};

  // modulo unit: folds 16 hash bits at a time, a multiply then a remainder fold, quotient by reciprocal multiply
  assign mod_x   = {16'(r_q), sh_q[63:48]};
  assign mod_quo = 32'(mod_prod_q >> (32 + SW));
  assign mod_rem = mod_x_q - mod_quo * 32'(SLOTS);

  assign hit_cnt  = kind_q ? cur_cnt_q - 32'd1 : cur_cnt_q + amount_q;
  assign dec_free = kind_q && ((hit_cnt == 32'd0) || hit_cnt[31]);
  assign stays    = (hole_q <= j_q) ? ((r_q > hole_q) && (r_q <= j_q))
                                    : ((r_q > hole_q) || (r_q <= j_q));

  always_comb begin
    key_we    = 1'b0;
    key_waddr = {idx_q, wc_q};
    key_wdata = key_q[ridx];
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = {1'b0, amount_q};
    case (cmd_i)
      CMD_CLEAR: cnt_we = 1'b1;
      CMD_INSW: begin
        key_we    = 1'b1;
        cnt_we    = wc_last;
        cnt_wdata = {1'b1, amount_q};
      end
      CMD_HIT: begin
        cnt_we    = 1'b1;
        cnt_wdata = {!dec_free, hit_cnt};
      end
      CMD_CPW: begin
        key_we    = 1'b1;
        key_waddr = {hole_q, wc_q};
        key_wdata = scratch_q[ridx];
        cnt_we    = wc_last;
        cnt_waddr = hole_q;
        cnt_wdata = {1'b1, mv_cnt_q};
      end
      CMD_CPCLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = j_q;
        cnt_wdata = {1'b0, mv_cnt_q};
      end
      default: ;
    endcase
  end

  assign key_raddr = (cmd_i == CMD_LRD) ? {j_q, wc_q} : {idx_q, wc_q};
  assign cnt_raddr = (cmd_i == CMD_DRD) ? j_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rdata_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      idx_q      <= '0;
      wc_q       <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (accept) pos_q <= complete ? '0 : pos_q + 1'b1;
      case (cmd_i)
        CMD_CLEAR: idx_q <= nxt(idx_q);
        CMD_PINIT: idx_q <= r_q;
        CMD_NEXT:  idx_q <= nxt(idx_q);
        default: ;
      endcase
      case (cmd_i)
        CMD_PCHK, CMD_DUCHK, CMD_DDEC: wc_q <= '0;
        CMD_CCHK, CMD_INSW, CMD_LWR, CMD_CPW: wc_q <= wc_last ? '0 : wc_q + 1'b1;
        default: ;
      endcase
      if (cmd_i == CMD_OUT && out_free) m_tvalid_q <= 1'b1;
      else if (m_axis_tready_i) m_tvalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < KW; i++) begin
        if (PW'(i) == pos_q) key_q[i] <= s_axis_tdata_i[63:0];
        else if (complete && (PW'(i) > pos_q)) key_q[i] <= '0;
      end
      if (complete) begin
        kind_q   <= s_axis_tuser_i;
        amount_q <= s_axis_tdata_i[95:64];
        h_q      <= HashBasis;
        bc_q     <= '0;
        hsel_q   <= 1'b0;
      end
    end
    case (cmd_i)
      CMD_HASH: begin
        h_q  <= hnext;
        bc_q <= bc_q + 1'b1;
        if (bc_last) begin
          sh_q <= hnext;
          r_q  <= '0;
          mc_q <= '0;
        end
      end
      CMD_MOD: begin
        // even step: multiply, odd step: fold back the remainder
        if (!mc_q[0]) begin
          mod_x_q    <= mod_x;
          mod_prod_q <= {33'd0, mod_x} * {32'd0, Recip};
          sh_q       <= {sh_q[47:0], 16'd0};
        end else begin
          r_q <= SW'(mod_rem);
        end
        mc_q <= mc_q + 1'b1;
      end
      CMD_PINIT: n_q <= '0;
      CMD_PCHK:  cur_cnt_q <= cnt_rdata_q[31:0];
      CMD_NEXT:  n_q <= n_q + 1'b1;
      CMD_INSW: begin
        res_cnt_q <= amount_q;
        res_st_q  <= StOk;
      end
      CMD_HIT: begin
        res_cnt_q <= hit_cnt;
        res_st_q  <= StOk;
        hole_q    <= idx_q;
        j_q       <= idx_q;
        n_q       <= '0;
      end
      CMD_FAIL: begin
        res_cnt_q <= '0;
        res_st_q  <= kind_q ? StNotFound : StFull;
      end
      CMD_DNEXT: begin
        j_q <= nxt(j_q);
        n_q <= n_q + 1'b1;
      end
      CMD_DUCHK: mv_cnt_q <= cnt_rdata_q[31:0];
      CMD_LWR: begin
        scratch_q[wc_q] <= key_rdata_q;
        if (wc_last) begin
          h_q    <= HashBasis;
          bc_q   <= '0;
          hsel_q <= 1'b1;
        end
      end
      CMD_CPCLR: hole_q <= j_q;
      CMD_OUT: begin
        if (out_free) begin
          m_tdata_q <= res_cnt_q;
          m_tuser_q <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  always_comb begin
    status_o.key_done = accept && complete;
    status_o.bc_last  = bc_last;
    status_o.mc_last  = (mc_q == 3'd7);
    status_o.used     = cnt_rdata_q[32];
    status_o.word_eq  = (key_rdata_q == key_q[ridx]);
    status_o.wc_last  = wc_last;
    status_o.n_last   = (n_q == SW'(SLOTS - 1));
    status_o.idx_last = (idx_q == SW'(SLOTS - 1));
    status_o.dec_free = dec_free;
    status_o.stays    = stays;
    status_o.out_free = out_free;
    status_o.kind     = kind_q;
  end

  `HKCT_ASSERT_IMP(a_wc_range, 1'b1, wc_q <= PW'(KW - 1), "word counter past key length")
  `HKCT_ASSERT_NXT(a_pos_restart, accept && complete, pos_q == '0, "word position not restarted")
  `HKCT_ASSERT_NXT(a_out_load, (cmd_i == CMD_OUT) && out_free, m_tvalid_q, "result not presented")
  `HKCT_ASSERT_IMP(a_status_code, m_tvalid_q, m_tuser_q != 2'd3, "undefined status code")

endmodule

// File: rtl/hashed_key_count_table.sv
// Top level of the hashed key count table: controller plus datapath.
// Depends on hkct_pkg, hkct_ctrl and hkct_dp.
//
//  channel   | direction | tdata                   | tuser  | tlast
//  s_axis    | in        | key_word, amount        | kind   | word_last
//  m_axis    | out       | count                   | status | -
//
// After reset a clearing pass over all SLOTS slots runs before the first request.
// A word that does not complete a key is only stored.
// A completing word takes KEY_BYTES hash steps, the modulo steps and a set-up
// step, then probes slot after slot: an empty slot ends the probe, and each used
// slot probed has its key compared word by word; the write-back follows. Each
// used slot examined by deletion costs a reload, rehash and modulo; a stalled
// output holds the next result back in the output state, where no words are taken.
module hashed_key_count_table
  import hkct_pkg::*;
#(
  parameter int SLOTS     = 256,
  parameter int KEY_BYTES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,  // key_word [63:0], amount [95:64]
  input  logic         s_axis_tlast_i,  // word_last
  input  logic         s_axis_tuser_i,  // kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,  // count [31:0]
  output logic [1:0]   m_axis_tuser_o   // status [1:0]
);

  hkct_cmd_e    cmd;
  hkct_status_t status;

  hkct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  hkct_dp #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
